FILE: rtl/tgpe_pkg.sv
package tgpe_pkg;

    localparam int MAX_FONT_WIDTH  = 16;
    localparam int MAX_FONT_HEIGHT = 32;

    // register widths follow from the glyph cell limits
    localparam int FW_W     = $clog2(MAX_FONT_WIDTH) + 1;
    localparam int RASTER_W = $clog2(MAX_FONT_HEIGHT);

    localparam int PIX_PER_BYTE = 8;
    localparam int CNT_W        = $clog2(PIX_PER_BYTE) + 1;
    localparam int SHIFT_W      = $clog2(PIX_PER_BYTE);

    localparam int COLOR_W      = 8;
    localparam int FLAGS_W      = 6;
    localparam int POS_W        = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 8;

    localparam logic [7:0] MSB_BIT  = 8'h80;
    localparam logic [7:0] ALL_BITS = 8'hFF;
    localparam logic [COLOR_W-1:0] BRIGHT_LIMIT = COLOR_W'(16);
    localparam logic [COLOR_W-1:0] BRIGHT_BIT   = COLOR_W'(8);

    localparam int ATTR_UNDERLINE = 0;
    localparam int ATTR_LEFT      = 1;
    localparam int ATTR_RIGHT     = 2;
    localparam int ATTR_BOLD      = 3;
    localparam int ATTR_BLINK     = 4;
    localparam int ATTR_REVERSE   = 5;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FONT_WIDTH     = 3'd0,
        REG_UNDERLINE_LINE = 3'd1,
        REG_CURSOR_VISIBLE = 3'd2,
        REG_CURSOR_ROW     = 3'd3,
        REG_CURSOR_COL     = 3'd4,
        REG_CURSOR_START   = 3'd5,
        REG_CURSOR_END     = 3'd6
    } reg_index_t;

    typedef logic [COLOR_W-1:0] color_t;

    typedef struct packed {
        logic [PIX_PER_BYTE-1:0] bits;
        color_t                  fore;
        color_t                  back;
        logic [CNT_W-1:0]        count;
    } cmd_t;

endpackage

FILE: rtl/tgpe_front.sv
module tgpe_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tgpe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tgpe_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               accept,
    input  logic [tgpe_pkg::POS_W-1:0]         text_row,
    input  logic [tgpe_pkg::POS_W-1:0]         char_col,
    input  logic [tgpe_pkg::RASTER_W-1:0]      raster_line,
    input  logic                               byte_index,
    input  logic [tgpe_pkg::PIX_PER_BYTE-1:0]  font_byte,
    input  tgpe_pkg::color_t                   fore_index,
    input  tgpe_pkg::color_t                   back_index,
    input  logic [tgpe_pkg::FLAGS_W-1:0]       attribute_flags,
    output logic                               cmd_push,
    output tgpe_pkg::cmd_t                     cmd
);

    logic [tgpe_pkg::FW_W-1:0]     font_width_reg;
    logic [tgpe_pkg::RASTER_W-1:0] underline_line_reg;
    logic                          cursor_visible_reg;
    logic [tgpe_pkg::POS_W-1:0]    cursor_row_reg;
    logic [tgpe_pkg::POS_W-1:0]    cursor_col_reg;
    logic [tgpe_pkg::RASTER_W-1:0] cursor_start_reg;
    logic [tgpe_pkg::RASTER_W-1:0] cursor_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            font_width_reg     <= tgpe_pkg::FW_W'(8);
            underline_line_reg <= tgpe_pkg::RASTER_W'(15);
            cursor_visible_reg <= 1'b0;
            cursor_row_reg     <= '0;
            cursor_col_reg     <= '0;
            cursor_start_reg   <= tgpe_pkg::RASTER_W'(14);
            cursor_end_reg     <= tgpe_pkg::RASTER_W'(15);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tgpe_pkg::REG_FONT_WIDTH:
                    font_width_reg <= cfg_data[tgpe_pkg::FW_W-1:0];
                tgpe_pkg::REG_UNDERLINE_LINE:
                    underline_line_reg <= cfg_data[tgpe_pkg::RASTER_W-1:0];
                tgpe_pkg::REG_CURSOR_VISIBLE:
                    cursor_visible_reg <= cfg_data[0];
                tgpe_pkg::REG_CURSOR_ROW:
                    cursor_row_reg <= cfg_data[tgpe_pkg::POS_W-1:0];
                tgpe_pkg::REG_CURSOR_COL:
                    cursor_col_reg <= cfg_data[tgpe_pkg::POS_W-1:0];
                tgpe_pkg::REG_CURSOR_START:
                    cursor_start_reg <= cfg_data[tgpe_pkg::RASTER_W-1:0];
                tgpe_pkg::REG_CURSOR_END:
                    cursor_end_reg <= cfg_data[tgpe_pkg::RASTER_W-1:0];
                default:
                    ;
            endcase
        end
    end

    logic [tgpe_pkg::FW_W-1:0]         width_eff;
    logic [tgpe_pkg::FW_W-1:0]         width_m1;
    logic [tgpe_pkg::FW_W-1:0]         bytes_per_row;
    logic [tgpe_pkg::FW_W-1:0]         byte_pos;
    logic [tgpe_pkg::FW_W-1:0]         remain;
    logic                              in_range;
    logic                              last_byte;
    logic                              in_cursor;
    logic [tgpe_pkg::PIX_PER_BYTE-1:0] right_bit;
    logic [tgpe_pkg::PIX_PER_BYTE-1:0] bits;
    tgpe_pkg::color_t                  fore_adj;
    tgpe_pkg::color_t                  back_adj;
    logic [tgpe_pkg::CNT_W-1:0]        count;

    always_comb
    begin
        if (font_width_reg == '0)
            width_eff = tgpe_pkg::FW_W'(1);
        else if (font_width_reg > tgpe_pkg::FW_W'(tgpe_pkg::MAX_FONT_WIDTH))
            width_eff = tgpe_pkg::FW_W'(tgpe_pkg::MAX_FONT_WIDTH);
        else
            width_eff = font_width_reg;

        width_m1      = width_eff - tgpe_pkg::FW_W'(1);
        bytes_per_row = tgpe_pkg::FW_W'(({1'b0, width_eff} + (tgpe_pkg::FW_W + 1)'(7))
                        >> tgpe_pkg::SHIFT_W);
        byte_pos      = tgpe_pkg::FW_W'(byte_index);
        in_range      = byte_pos < bytes_per_row;
        last_byte     = (byte_pos + tgpe_pkg::FW_W'(1)) == bytes_per_row;
        right_bit     = tgpe_pkg::MSB_BIT >> width_m1[tgpe_pkg::SHIFT_W-1:0];

        in_cursor = cursor_visible_reg && (text_row == cursor_row_reg)
                    && (char_col == cursor_col_reg)
                    && (cursor_start_reg <= raster_line)
                    && (raster_line <= cursor_end_reg);

        bits = font_byte;
        if (attribute_flags[tgpe_pkg::ATTR_LEFT] && !byte_index)
            bits = bits | tgpe_pkg::MSB_BIT;
        if (attribute_flags[tgpe_pkg::ATTR_RIGHT] && last_byte)
            bits = bits | right_bit;
        if (attribute_flags[tgpe_pkg::ATTR_UNDERLINE] && (raster_line == underline_line_reg))
            bits = tgpe_pkg::ALL_BITS;
        if (in_cursor)
            bits = bits ^ tgpe_pkg::ALL_BITS;

        fore_adj = fore_index;
        if (attribute_flags[tgpe_pkg::ATTR_BOLD] && (fore_index < tgpe_pkg::BRIGHT_LIMIT))
            fore_adj = fore_index | tgpe_pkg::BRIGHT_BIT;
        back_adj = back_index;
        if (attribute_flags[tgpe_pkg::ATTR_BLINK] && (back_index < tgpe_pkg::BRIGHT_LIMIT))
            back_adj = back_index | tgpe_pkg::BRIGHT_BIT;

        // pixels left in the row past this byte's left edge
        remain = width_eff - tgpe_pkg::FW_W'({byte_index, {tgpe_pkg::SHIFT_W{1'b0}}});
        if (!last_byte || (remain > tgpe_pkg::FW_W'(tgpe_pkg::PIX_PER_BYTE)))
            count = tgpe_pkg::CNT_W'(tgpe_pkg::PIX_PER_BYTE);
        else
            count = remain[tgpe_pkg::CNT_W-1:0];
    end

    always_comb
    begin
        cmd.bits  = bits;
        cmd.count = count;
        if (attribute_flags[tgpe_pkg::ATTR_REVERSE])
        begin
            cmd.fore = back_adj;
            cmd.back = fore_adj;
        end
        else
        begin
            cmd.fore = fore_adj;
            cmd.back = back_adj;
        end
    end

    // bytes beyond the glyph row are taken and dropped
    assign cmd_push = accept && in_range;

endmodule

FILE: rtl/tgpe_queue.sv
module tgpe_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  tgpe_pkg::cmd_t wr_cmd,
    input  logic           rd_en,
    output tgpe_pkg::cmd_t rd_cmd,
    output logic           full,
    output logic           not_empty
);

    tgpe_pkg::cmd_t                slot_reg [tgpe_pkg::QDEPTH];
    logic [tgpe_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [tgpe_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [tgpe_pkg::QCNT_W-1:0]   fill_reg;
    logic [tgpe_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [tgpe_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [tgpe_pkg::QCNT_W-1:0]   fill_next;
    logic                          do_wr;
    logic                          do_rd;

    assign full      = fill_reg == tgpe_pkg::QCNT_W'(tgpe_pkg::QDEPTH);
    assign not_empty = fill_reg != '0;
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign rd_cmd    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr)
        begin
            if (wr_ptr_reg == tgpe_pkg::QPTR_W'(tgpe_pkg::QDEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + tgpe_pkg::QPTR_W'(1);
        end
        if (do_rd)
        begin
            if (rd_ptr_reg == tgpe_pkg::QPTR_W'(tgpe_pkg::QDEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + tgpe_pkg::QPTR_W'(1);
        end
        if (do_wr && !do_rd)
            fill_next = fill_reg + tgpe_pkg::QCNT_W'(1);
        else if (do_rd && !do_wr)
            fill_next = fill_reg - tgpe_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_cmd;
    end

endmodule

FILE: rtl/tgpe_back.sv
module tgpe_back (
    input  logic             clk,
    input  logic             rst_n,
    input  tgpe_pkg::cmd_t   head_cmd,
    input  logic             head_valid,
    output logic             head_take,
    input  logic             pop,
    output logic             empty,
    output tgpe_pkg::color_t pixel_color,
    output logic             last_pixel
);

    logic                              cur_valid_reg;
    logic                              cur_valid_next;
    logic [tgpe_pkg::PIX_PER_BYTE-1:0] bits_reg;
    logic [tgpe_pkg::PIX_PER_BYTE-1:0] bits_next;
    tgpe_pkg::color_t                  fore_reg;
    tgpe_pkg::color_t                  fore_next;
    tgpe_pkg::color_t                  back_reg;
    tgpe_pkg::color_t                  back_next;
    logic [tgpe_pkg::CNT_W-1:0]        remain_reg;
    logic [tgpe_pkg::CNT_W-1:0]        remain_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    tgpe_pkg::color_t                  color_reg;
    tgpe_pkg::color_t                  color_next;
    logic                              last_reg;
    logic                              last_next;
    logic                              advance;
    logic                              emit;
    logic                              finishing;

    // output register frees up when empty or when its beat is taken
    assign advance   = !out_valid_reg || pop;
    assign emit      = cur_valid_reg && advance;
    assign finishing = emit && (remain_reg == tgpe_pkg::CNT_W'(1));
    assign head_take = head_valid && (!cur_valid_reg || finishing);

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        bits_next      = bits_reg;
        fore_next      = fore_reg;
        back_next      = back_reg;
        remain_next    = remain_reg;
        out_valid_next = out_valid_reg;
        color_next     = color_reg;
        last_next      = last_reg;

        if (advance)
            out_valid_next = emit;

        if (emit)
        begin
            color_next  = bits_reg[tgpe_pkg::PIX_PER_BYTE-1] ? fore_reg : back_reg;
            last_next   = remain_reg == tgpe_pkg::CNT_W'(1);
            bits_next   = bits_reg << 1;
            remain_next = remain_reg - tgpe_pkg::CNT_W'(1);
            if (finishing)
                cur_valid_next = 1'b0;
        end

        // next byte loads behind the last pixel without a gap
        if (head_take)
        begin
            cur_valid_next = 1'b1;
            bits_next      = head_cmd.bits;
            fore_next      = head_cmd.fore;
            back_next      = head_cmd.back;
            remain_next    = head_cmd.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            remain_reg    <= '0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
            remain_reg    <= remain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg  <= bits_next;
        fore_reg  <= fore_next;
        back_reg  <= back_next;
        color_reg <= color_next;
        last_reg  <= last_next;
    end

    assign empty       = !out_valid_reg;
    assign pixel_color = color_reg;
    assign last_pixel  = last_reg;

endmodule

FILE: rtl/text_glyph_row_pixel_expander_core.sv
// path: queue slot, then serializer byte registers, then pixel output register
// throughput: one pixel per cycle unless pop holds the output back; a byte gives
// 8 pixels or the font width remainder on a row's last byte; bytes follow without gaps
// the pixel serializer sets the rate; a 2-entry queue lets input run ahead of it
// reset: async active low, clears the queue and serializer, loads register defaults
module text_glyph_row_pixel_expander_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tgpe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tgpe_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               push,
    output logic                               full,
    input  logic [tgpe_pkg::POS_W-1:0]         text_row,
    input  logic [tgpe_pkg::POS_W-1:0]         char_col,
    input  logic [tgpe_pkg::RASTER_W-1:0]      raster_line,
    input  logic                               byte_index,
    input  logic [tgpe_pkg::PIX_PER_BYTE-1:0]  font_byte,
    input  tgpe_pkg::color_t                   fore_index,
    input  tgpe_pkg::color_t                   back_index,
    input  logic [tgpe_pkg::FLAGS_W-1:0]       attribute_flags,
    output logic                               empty,
    input  logic                               pop,
    output tgpe_pkg::color_t                   pixel_color,
    output logic                               last_pixel
);

    tgpe_pkg::cmd_t front_cmd;
    tgpe_pkg::cmd_t head_cmd;
    logic           front_push;
    logic           head_valid;
    logic           head_take;
    logic           accept;

    assign accept = push && !full;

    tgpe_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .accept          (accept),
        .text_row        (text_row),
        .char_col        (char_col),
        .raster_line     (raster_line),
        .byte_index      (byte_index),
        .font_byte       (font_byte),
        .fore_index      (fore_index),
        .back_index      (back_index),
        .attribute_flags (attribute_flags),
        .cmd_push        (front_push),
        .cmd             (front_cmd)
    );

    tgpe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (front_push),
        .wr_cmd    (front_cmd),
        .rd_en     (head_take),
        .rd_cmd    (head_cmd),
        .full      (full),
        .not_empty (head_valid)
    );

    tgpe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_cmd    (head_cmd),
        .head_valid  (head_valid),
        .head_take   (head_take),
        .pop         (pop),
        .empty       (empty),
        .pixel_color (pixel_color),
        .last_pixel  (last_pixel)
    );

endmodule

FILE: rtl/tgpe_checker.sv
module tgpe_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             full,
    input logic             empty,
    input logic             pop,
    input tgpe_pkg::color_t pixel_color,
    input logic             last_pixel
);

    // a stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(pixel_color) && $stable(last_pixel)))
        else $error("waiting pixel changed or vanished");

    // pixels of one byte come without gaps
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last_pixel) |=> !empty)
        else $error("gap inside a byte's pixel run");

    // a full queue means the serializer is already busy
    a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("queue full while no pixel is out");

    // nothing to show right after reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> (empty && !full))
        else $error("result side not empty after reset");

endmodule

bind text_glyph_row_pixel_expander_core tgpe_checker u_tgpe_checker (.*);
